### rtl/core/indexed_ordered_list_defines.svh
// assertion macros for the indexed ordered list
// no dependencies; included by the modules that carry assertions
`ifndef INDEXED_ORDERED_LIST_DEFINES_SVH
`define INDEXED_ORDERED_LIST_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IOL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iol assertion failed");

// next-cycle implication, checked out of reset
`define IOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iol assertion failed");

`endif

### rtl/core/iol_pkg.sv
// shared types and constants for the indexed ordered list
// no dependencies; used by every module of the block
package iol_pkg;

  localparam int DATA_W          = 32;
  localparam int POS_W           = 8;
  localparam int OPCODE_W        = 3;
  localparam int STATUS_W        = 3;
  localparam int CAPACITY_DEF    = 32;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_DELETE     = 3'd5,
    OP_REMOVE     = 3'd6,
    OP_READ       = 3'd7
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // what the back end does with the list
  typedef enum logic [1:0] {
    K_INS = 2'd0,
    K_DEL = 2'd1,
    K_RMV = 2'd2,
    K_RD  = 2'd3
  } kind_t;

  // where the position comes from
  typedef enum logic [1:0] {
    P_FRONT = 2'd0,
    P_BACK  = 2'd1,
    P_POS   = 2'd2
  } psel_t;

  typedef struct packed {
    kind_t              kind;
    psel_t              psel;
    logic               want_data;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
  } cmd_t;

endpackage

### rtl/core/iol_front.sv
// front end: input register and opcode decode into a list command
// depends on iol_pkg
module iol_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [iol_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [iol_pkg::POS_W-1:0]     in_position,
  input  logic [iol_pkg::DATA_W-1:0]    in_item_value,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output iol_pkg::cmd_t                 cmd
);

  logic          fr_valid_r, fr_valid_nxt;
  iol_pkg::cmd_t fr_cmd_r, fr_cmd_nxt;
  logic          accept;

  assign in_ready  = !fr_valid_r || cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = fr_valid_r;
  assign cmd       = fr_cmd_r;

  always_comb begin
    fr_cmd_nxt           = fr_cmd_r;
    fr_valid_nxt         = fr_valid_r;
    if (accept) begin
      fr_valid_nxt         = 1'b1;
      fr_cmd_nxt.pos       = in_position;
      fr_cmd_nxt.value     = in_item_value;
      fr_cmd_nxt.want_data = 1'b0;
      fr_cmd_nxt.psel      = iol_pkg::P_POS;
      case (iol_pkg::opcode_t'(in_opcode))
        iol_pkg::OP_PUSH_FRONT: begin
          fr_cmd_nxt.kind = iol_pkg::K_INS;
          fr_cmd_nxt.psel = iol_pkg::P_FRONT;
        end
        iol_pkg::OP_PUSH_BACK: begin
          fr_cmd_nxt.kind = iol_pkg::K_INS;
          fr_cmd_nxt.psel = iol_pkg::P_BACK;
        end
        iol_pkg::OP_POP_FRONT: begin
          fr_cmd_nxt.kind      = iol_pkg::K_DEL;
          fr_cmd_nxt.psel      = iol_pkg::P_FRONT;
          fr_cmd_nxt.want_data = 1'b1;
        end
        iol_pkg::OP_POP_BACK: begin
          fr_cmd_nxt.kind      = iol_pkg::K_DEL;
          fr_cmd_nxt.psel      = iol_pkg::P_BACK;
          fr_cmd_nxt.want_data = 1'b1;
        end
        iol_pkg::OP_INSERT: begin
          fr_cmd_nxt.kind = iol_pkg::K_INS;
        end
        iol_pkg::OP_DELETE: begin
          fr_cmd_nxt.kind = iol_pkg::K_DEL;
        end
        iol_pkg::OP_REMOVE: begin
          fr_cmd_nxt.kind = iol_pkg::K_RMV;
        end
        default: begin
          fr_cmd_nxt.kind      = iol_pkg::K_RD;
          fr_cmd_nxt.want_data = 1'b1;
        end
      endcase
    end else if (cmd_ready) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_cmd_r <= fr_cmd_nxt;
  end

endmodule

### rtl/core/iol_queue.sv
// short command queue between front and back end
// depends on iol_pkg
module iol_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  iol_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output iol_pkg::cmd_t pop_cmd
);

  localparam int QD = iol_pkg::QUEUE_DEPTH;
  localparam int QA = (QD > 1) ? $clog2(QD) : 1;
  localparam int QC = $clog2(QD + 1);

  iol_pkg::cmd_t  slots_r [QD];
  logic [QA-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QA-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QC-1:0]  fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign push_ready = fill_r < QC'(QD);
  assign pop_valid  = fill_r != '0;
  assign pop_cmd    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QA'(QD - 1)) ? '0 : wr_ptr_r + QA'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QA'(QD - 1)) ? '0 : rd_ptr_r + QA'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + QC'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - QC'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/core/iol_back.sv
// back end: row of list cells, shift/compare update and result register
// depends on iol_pkg and indexed_ordered_list_defines.svh
`include "indexed_ordered_list_defines.svh"

module iol_back #(
  parameter int CAPACITY    = iol_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = iol_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  iol_pkg::cmd_t                 cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [iol_pkg::DATA_W-1:0]    out_data,
  output logic [iol_pkg::STATUS_W-1:0]  out_status,
  output logic [$clog2(CAPACITY+1)-1:0] out_count,
  output logic                          out_empty
);

  localparam int DW    = iol_pkg::DATA_W;
  localparam int SW    = (VALUE_WIDTH < DW) ? VALUE_WIDTH : DW;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW    = (CNT_W > iol_pkg::POS_W) ? CNT_W : iol_pkg::POS_W;

  logic [SW-1:0]       cells_r [CAPACITY];
  logic [SW-1:0]       cells_nxt [CAPACITY];
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DW-1:0]       out_data_r, out_data_nxt;
  iol_pkg::status_t    out_status_r, status;
  logic [CNT_W-1:0]    out_count_r;
  logic                out_empty_r;
  logic                out_err;

  logic                fire, full, empty, found, ok, ins_do, del_do;
  logic [PW-1:0]       count_ext, pos_ext, p_ins, p_del, p_sel;
  logic [IDX_W-1:0]    p_idx;
  logic [CAPACITY-1:0] match, ge_pos, ge_rm, ge;
  logic [SW-1:0]       v, rd_val;

  assign fire      = cmd_valid && (!out_valid_r || out_ready);
  assign cmd_ready = fire;

  assign full      = count_r == CNT_W'(CAPACITY);
  assign empty     = count_r == '0;
  assign count_ext = PW'(count_r);
  assign pos_ext   = PW'(cmd.pos);
  assign v         = cmd.value[SW-1:0];

  // resolve the position for the command
  always_comb begin
    case (cmd.psel)
      iol_pkg::P_FRONT: begin
        p_ins = '0;
        p_del = '0;
      end
      iol_pkg::P_BACK: begin
        p_ins = count_ext;
        p_del = count_ext - PW'(1);
      end
      default: begin
        p_ins = (pos_ext >= count_ext) ? count_ext : pos_ext;
        p_del = pos_ext;
      end
    endcase
    p_sel = (cmd.kind == iol_pkg::K_INS) ? p_ins : p_del;
  end

  assign p_idx  = p_sel[IDX_W-1:0];
  assign rd_val = cells_r[p_idx];

  // per-cell position compare and value match
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge_pos[i] = PW'(i) >= p_sel;
      match[i]  = (PW'(i) < count_ext) && (cells_r[i] == v);
    end
  end

  // cells from the first match upward
  assign ge_rm = match | ~(match - CAPACITY'(1));
  assign found = |match;
  assign ge    = (cmd.kind == iol_pkg::K_RMV) ? ge_rm : ge_pos;

  always_comb begin
    case (cmd.kind)
      iol_pkg::K_INS: begin
        status = full ? iol_pkg::ST_FULL : iol_pkg::ST_OK;
      end
      iol_pkg::K_RMV: begin
        if (empty) begin
          status = iol_pkg::ST_EMPTY;
        end else if (!found) begin
          status = iol_pkg::ST_NOTFOUND;
        end else begin
          status = iol_pkg::ST_OK;
        end
      end
      default: begin
        if (empty) begin
          status = iol_pkg::ST_EMPTY;
        end else if (cmd.psel == iol_pkg::P_POS && pos_ext >= count_ext) begin
          status = iol_pkg::ST_RANGE;
        end else begin
          status = iol_pkg::ST_OK;
        end
      end
    endcase
  end

  assign ok     = status == iol_pkg::ST_OK;
  assign ins_do = ok && cmd.kind == iol_pkg::K_INS;
  assign del_do = ok && (cmd.kind inside {iol_pkg::K_DEL, iol_pkg::K_RMV});

  // shift up to open a gap, or down to close one
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
      if (ins_do && ge[i]) begin
        if (i == 0) begin
          cells_nxt[i] = v;
        end else if (!ge[i-1]) begin
          cells_nxt[i] = v;
        end else begin
          cells_nxt[i] = cells_r[i-1];
        end
      end else if (del_do && ge[i] && i < CAPACITY - 1) begin
        cells_nxt[i] = cells_r[i+1];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_do) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (del_do) begin
      count_nxt = count_r - CNT_W'(1);
    end
    out_data_nxt  = (ok && cmd.want_data) ? DW'(rd_val) : '0;
    out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= fire ? count_nxt : count_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cells_r      <= cells_nxt;
      out_data_r   <= out_data_nxt;
      out_status_r <= status;
      out_count_r  <= count_nxt;
      out_empty_r  <= count_nxt == '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;
  assign out_empty  = out_empty_r;

  // held result carries an error status
  assign out_err = out_status_r != iol_pkg::ST_OK;

  `IOL_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `IOL_ASSERT_NEXT(a_count_hold, clk, rst_n, !fire, $stable(count_r))
  `IOL_ASSERT_IMPL(a_data_zero, clk, rst_n, out_valid_r && out_err, out_data_r == '0)
  `IOL_ASSERT_IMPL(a_empty_flag, clk, rst_n, out_valid_r, out_empty_r == (out_count_r == '0))

endmodule

### rtl/core/indexed_ordered_list.sv
// path: a request beat is taken into the input register, passes the command queue and the list
//   update, and its result beat leaves the output register
// throughput: one request per cycle when nothing stalls; the back end updates the whole cell row at once
// reset: clears the entry count and all handshake state; list cells are not cleared
//   and no clearing pass runs, so requests are taken from the first cycle after reset
module indexed_ordered_list #(
  parameter int CAPACITY    = iol_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = iol_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [iol_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [iol_pkg::POS_W-1:0]     in_position,
  input  logic [iol_pkg::DATA_W-1:0]    in_item_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [iol_pkg::DATA_W-1:0]    out_data_out,
  output logic [iol_pkg::STATUS_W-1:0]  out_status,
  output logic [$clog2(CAPACITY+1)-1:0] out_count_out,
  output logic                          out_is_empty
);

  // front to queue
  logic          fq_valid, fq_ready;
  iol_pkg::cmd_t fq_cmd;

  // queue to back end
  logic          qb_valid, qb_ready;
  iol_pkg::cmd_t qb_cmd;

  // decode the opcode into an insert, delete, remove or read command
  iol_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_position   (in_position),
    .in_item_value (in_item_value),
    .cmd_valid     (fq_valid),
    .cmd_ready     (fq_ready),
    .cmd           (fq_cmd)
  );

  // lets the front keep taking beats while the result side is stalled, until the queue is full
  iol_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  // cell row: every cell shifts or compares in parallel, one command per cycle while results are taken
  iol_back #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (qb_valid),
    .cmd_ready  (qb_ready),
    .cmd        (qb_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data_out),
    .out_status (out_status),
    .out_count  (out_count_out),
    .out_empty  (out_is_empty)
  );

endmodule
